// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/nsr_pkg.sv =====
// ---------------------------------------------------------------------------
// Newton square root package
// Default sizes and fixed field widths shared by the block and its channels.
// ---------------------------------------------------------------------------
package nsr_pkg;

  localparam int RADICAND_BITS_DEF   = 24;
  localparam int FRACTION_BITS_DEF   = 16;
  localparam int LAST_STEP_INDEX_DEF = 50;

  localparam int ROOT_BITS = 29;

endpackage

// ===== hdl/nsr_channels.sv =====
// ---------------------------------------------------------------------------
// Newton square root channels
// Valid/ready channel interfaces for the radicand and the result item.
// ---------------------------------------------------------------------------
interface nsr_in_if #(
  parameter int RADICAND_BITS = nsr_pkg::RADICAND_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [RADICAND_BITS-1:0] radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

interface nsr_out_if;
  import nsr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ROOT_BITS-1:0] square_root;
  logic                 not_converged;

  modport source (output valid, output square_root, output not_converged, input ready);
  modport sink   (input valid, input square_root, input not_converged, output ready);
endinterface

// ===== hdl/newton_square_root_top.sv =====
// ---------------------------------------------------------------------------
// Newton square root
// Fixed-point Newton iteration for the square root of an unsigned integer.
// ---------------------------------------------------------------------------
// The radicand arrives on in_chan and one result item leaves on out_chan,
// both valid/ready channels; an item moves when valid and ready are high.
// The block works on one item at a time and drops in_chan.ready while busy.
// Each Newton step runs one restoring division of the scaled radicand by
// the iterate, one quotient bit per cycle, followed by the update state.
// The division remainder and quotient also decide whether the iterate has
// squared exactly to the scaled radicand, which ends the iteration.
// At most LAST_STEP_INDEX + 1 steps run for one item; the block returns to
// idle as it writes the result to the output register and can then take
// the next item.
// The result waits in an output register. While the receiver stalls, the
// block may take the next radicand and work on it; that item then waits in
// its final update state until the output register is free.
// A synchronous active-low reset empties the output register and returns
// the sequencer to idle; no clearing pass is needed.
// ---------------------------------------------------------------------------
module newton_square_root_top #(
  parameter int RADICAND_BITS   = nsr_pkg::RADICAND_BITS_DEF,
  parameter int FRACTION_BITS   = nsr_pkg::FRACTION_BITS_DEF,
  parameter int LAST_STEP_INDEX = nsr_pkg::LAST_STEP_INDEX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  nsr_in_if.sink           in_chan,
  nsr_out_if.source        out_chan
);
  import nsr_pkg::*;

  localparam int IB  = RADICAND_BITS + FRACTION_BITS;
  localparam int QW  = RADICAND_BITS + 2 * FRACTION_BITS;
  localparam int BCW = $clog2(QW);
  localparam int SCW = ($clog2(LAST_STEP_INDEX + 1) < 1) ? 1 : $clog2(LAST_STEP_INDEX + 1);
  localparam int CW  = (IB > ROOT_BITS) ? IB : ROOT_BITS;

  localparam logic [BCW-1:0]       BIT_LAST  = BCW'(QW - 1);
  localparam logic [SCW-1:0]       STEP_LAST = SCW'(LAST_STEP_INDEX);
  localparam logic [IB-1:0]        N_ONE     = IB'(1) << FRACTION_BITS;
  localparam logic [CW-1:0]        ROOT_CAP  = CW'({ROOT_BITS{1'b1}});

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_UPD
  } state_t;

  state_t                   state_r;
  logic [RADICAND_BITS-1:0] x_r;
  logic [IB-1:0]            n_r;
  logic [IB-1:0]            rem_r;
  logic [QW-1:0]            dvd_r;
  logic [BCW-1:0]           bit_r;
  logic [SCW-1:0]           step_r;
  logic                     flag_r;
  logic                     out_valid_r;
  logic [ROOT_BITS-1:0]     out_root_r;
  logic                     out_nc_r;

  logic [QW-1:0]            target;
  logic [IB:0]              trial;
  logic [IB+1:0]            diff;
  logic                     q_bit;
  logic [QW-1:0]            quot;
  logic [QW:0]              sum;
  logic [QW-1:0]            half;
  logic [IB-1:0]            n_upd;
  logic                     match;
  logic                     out_free;
  logic                     item_done;
  logic [CW-1:0]            n_ext;
  logic [ROOT_BITS-1:0]     root_sat;

  assign target = {x_r, {(2 * FRACTION_BITS){1'b0}}};

  assign trial = {rem_r, dvd_r[QW-1]};
  assign diff  = {1'b0, trial} - {2'b00, n_r};
  assign q_bit = ~diff[IB+1];

  assign quot  = (n_r == '0) ? '0 : dvd_r;
  assign match = (n_r == '0) ? (x_r == '0) : ((rem_r == '0) && (dvd_r == QW'(n_r)));
  assign sum   = {1'b0, quot} + (QW + 1)'(n_r);
  assign half  = sum[QW:1];
  assign n_upd = (half[QW-1:IB] != '0) ? '1 : half[IB-1:0];

  assign n_ext    = CW'(n_r);
  assign root_sat = (n_ext > ROOT_CAP) ? {ROOT_BITS{1'b1}} : n_ext[ROOT_BITS-1:0];

  assign out_free  = !out_valid_r || out_chan.ready;
  assign item_done = (state_r == S_UPD) && (match || (step_r == STEP_LAST)) && out_free;

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.square_root   = out_root_r;
  assign out_chan.not_converged = out_nc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      bit_r       <= '0;
      flag_r      <= 1'b0;
    end else begin
      if (item_done) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid && in_chan.ready) begin
            x_r     <= in_chan.radicand;
            n_r     <= N_ONE;
            rem_r   <= '0;
            dvd_r   <= {in_chan.radicand, {(2 * FRACTION_BITS){1'b0}}};
            bit_r   <= BIT_LAST;
            step_r  <= '0;
            flag_r  <= 1'b0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= q_bit ? diff[IB-1:0] : trial[IB-1:0];
          dvd_r <= {dvd_r[QW-2:0], q_bit};
          bit_r <= bit_r - BCW'(1);
          if (bit_r == '0) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (match) begin
            if (out_free) begin
              out_root_r  <= root_sat;
              out_nc_r    <= flag_r;
              state_r     <= S_IDLE;
            end
          end else if (step_r == STEP_LAST) begin
            if (out_free) begin
              n_r         <= n_upd;
              flag_r      <= 1'b1;
              out_root_r  <= ((CW'(n_upd) > ROOT_CAP) ? {ROOT_BITS{1'b1}}
                                                        : ROOT_BITS'(n_upd));
              out_nc_r    <= 1'b1;
              state_r     <= S_IDLE;
            end
          end else begin
            n_r     <= n_upd;
            rem_r   <= '0;
            dvd_r   <= target;
            bit_r   <= BIT_LAST;
            step_r  <= step_r + SCW'(1);
            state_r <= S_DIV;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_step_bound, step_r <= STEP_LAST, "step counter ran past the last step")
  `ASSERT_NEXT(a_start_div, in_chan.valid && in_chan.ready, (state_r == S_DIV) && (step_r == '0) && (bit_r == BIT_LAST), "accepted item did not start a division")
  `ASSERT_NEXT(a_div_to_upd, (state_r == S_DIV) && (bit_r == '0), state_r == S_UPD, "division did not end in an update")
  `ASSERT_ALWAYS(a_no_accept_busy, !((state_r != S_IDLE) && in_chan.ready), "radicand taken while busy")

endmodule

// ===== test/newton_square_root_top_test.sv =====
// ---------------------------------------------------------------------------
// Newton square root testbench
// Sends radicands through the valid/ready input channel, predicts each root
// and convergence flag with a bit-true fixed-point Newton iteration, and
// checks every result item in order, with random idling on both sides.
// ---------------------------------------------------------------------------
module newton_square_root_top_test;
  import nsr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAD_BITS  = RADICAND_BITS_DEF;
  localparam int FRAC_BITS = FRACTION_BITS_DEF;
  localparam int LAST_STEP = LAST_STEP_INDEX_DEF;

  localparam logic [127:0] ITER_MAX  = (128'd1 << (RAD_BITS + FRAC_BITS)) - 128'd1;
  localparam logic [127:0] ROOT_MAX  = (128'd1 << ROOT_BITS) - 128'd1;
  localparam logic [127:0] QUOT_CAP  = 128'd1 << 62;
  localparam int           RANDOM_ITEMS = 258;
  localparam int           DRAIN_CYCLES = 3000;
  localparam longint       CYCLE_LIMIT  = 4_000_000;

  typedef struct packed {
    logic [ROOT_BITS-1:0] square_root;
    logic                 not_converged;
  } root_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  nsr_in_if  in_chan ();
  nsr_out_if out_chan ();

  newton_square_root_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic [RAD_BITS-1:0] pending_radicands[$];
  root_item_t          expected_roots[$];
  int                  total_radicands;
  int                  accepted_count;
  int                  result_count;
  int                  flagged_count;
  int                  error_count;
  longint              cycle_count;
  bit                  radicand_taken;

  always #5 clk = ~clk;

  function automatic root_item_t predict_square_root(input logic [RAD_BITS-1:0] x);
    logic [127:0] target;
    logic [127:0] iterate;
    logic [127:0] quotient;
    logic [127:0] next_iterate;
    root_item_t   item;
    target           = 128'(x) << (2 * FRAC_BITS);
    iterate          = 128'd1 << FRAC_BITS;
    item.not_converged = 1'b0;
    for (int step = 0; step <= LAST_STEP; step++) begin
      if (iterate * iterate == target) break;
      quotient = (iterate == 128'd0) ? 128'd0 : target / iterate;
      if (quotient > QUOT_CAP) quotient = QUOT_CAP;
      next_iterate = (iterate + quotient) >> 1;
      iterate      = (next_iterate > ITER_MAX) ? ITER_MAX : next_iterate;
      if (step == LAST_STEP) item.not_converged = 1'b1;
    end
    item.square_root = (iterate > ROOT_MAX) ? ROOT_MAX[ROOT_BITS-1:0]
                                            : iterate[ROOT_BITS-1:0];
    return item;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (error_count < 40) begin
      $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
               result_count, what, got, want);
    end
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, expected_roots.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    root_item_t want;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        expected_roots.push_back(predict_square_root(in_chan.radicand));
        accepted_count++;
        radicand_taken = 1'b1;
      end
      if (out_chan.valid && out_chan.ready) begin
        if (expected_roots.size() == 0) begin
          report_mismatch("arrived with no item outstanding", out_chan.square_root, 0);
        end else begin
          want = expected_roots.pop_front();
          if (out_chan.square_root !== want.square_root)
            report_mismatch("square_root", out_chan.square_root, want.square_root);
          if (out_chan.not_converged !== want.not_converged)
            report_mismatch("not_converged", out_chan.not_converged, want.not_converged);
          if (want.not_converged) flagged_count++;
        end
        result_count++;
      end
    end
  end

  always @(negedge clk) begin
    int sent;
    int send_idle_pct;
    int recv_idle_pct;
    sent = total_radicands - pending_radicands.size();
    if (sent < total_radicands / 3) begin
      send_idle_pct = 18;
      recv_idle_pct = 61;
    end else if (sent < 2 * total_radicands / 3) begin
      send_idle_pct = 61;
      recv_idle_pct = 18;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    if (rst_n) begin
      if (!in_chan.valid || radicand_taken) begin
        if (pending_radicands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_chan.valid    <= 1'b1;
          in_chan.radicand <= pending_radicands.pop_front();
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
      radicand_taken = 1'b0;
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    logic [RAD_BITS-1:0] directed[$];
    logic [RAD_BITS-1:0] value;
    int                  width;
    in_chan.valid    = 1'b0;
    in_chan.radicand = '0;
    out_chan.ready   = 1'b0;
    accepted_count   = 0;
    result_count     = 0;
    flagged_count    = 0;
    error_count      = 0;
    radicand_taken   = 1'b0;

    // Zero halves down to a zero iterate; the rest mix exact squares, which
    // stop early, with values that run every permitted step.
    directed = '{24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd9, 24'd15, 24'd16,
                 24'd100, 24'd144, 24'd255, 24'd256, 24'd65535, 24'd65536,
                 24'h100000, 24'h555555, 24'hAAAAAA, 24'h800000, 24'd16769025,
                 24'hFFFFFE, 24'hFFFFFF};
    foreach (directed[i]) pending_radicands.push_back(directed[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          value = RAD_BITS'($urandom_range(4095) * $urandom_range(4095, 0));
          width = $urandom_range(4095);
          value = RAD_BITS'(width * width);
        end
        5, 6, 7: value = RAD_BITS'($urandom);
        default: begin
          width = $urandom_range(RAD_BITS, 1);
          value = RAD_BITS'($urandom) & RAD_BITS'((64'd1 << width) - 1);
        end
      endcase
      pending_radicands.push_back(value);
    end
    total_radicands = pending_radicands.size();

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    while (accepted_count != total_radicands || expected_roots.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d radicands (%0d directed), checked %0d results in %0d cycles.",
             total_radicands, directed.size(), result_count, cycle_count);
    $display("%0d results hit the step limit, %0d converged exactly.",
             flagged_count, result_count - flagged_count);
    if (error_count == 0 && expected_roots.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/nsr_pkg.sv
hdl/nsr_channels.sv
hdl/newton_square_root_top.sv
test/newton_square_root_top_test.sv
